// ===== hw/rtl/hsbrgb_pkg.sv =====
package hsbrgb_pkg;

    // Q1.15 full scale
    localparam logic [15:0] Q15_ONE = 16'd32768;

    // Hue sector codes, hue * 6 integer part
    localparam logic [2:0] SECTOR_RED_YEL = 3'd0;
    localparam logic [2:0] SECTOR_YEL_GRN = 3'd1;
    localparam logic [2:0] SECTOR_GRN_CYN = 3'd2;
    localparam logic [2:0] SECTOR_CYN_BLU = 3'd3;
    localparam logic [2:0] SECTOR_BLU_MAG = 3'd4;
    localparam logic [2:0] SECTOR_MAG_RED = 3'd5;

    // Saturation and brightness of one input pixel, Q1.15
    typedef struct packed {
        logic [15:0] saturation;
        logic [15:0] brightness;
    } sat_bri_t;

    // One output pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Clamp a Q1.15 value to 1.0
    function automatic logic [15:0] clamp_q15(input logic [15:0] x);
        logic [15:0] y;
        y = (x > Q15_ONE) ? Q15_ONE : x;
        return y;
    endfunction

endpackage

// ===== hw/rtl/hsb_to_rgb_converter.sv =====
// HSB to RGB pixel converter. Each beat on the pixel side carries a hue (a fraction of a
// full turn, HUE_BITS wide) and a Q1.15 saturation and brightness (values above 1.0 are
// clamped to 1.0); each beat on the rgb side carries 8-bit red, green and blue, every
// channel being the exact channel value times 255 truncated toward zero. The block takes
// one pixel per clock while rgb_ready stays high; stage one clamps the inputs and splits
// hue * 6 into sector and fraction, stage two forms s * f and s * (1 - f), stage three
// builds p, q and t and routes them to the channels, stage four multiplies each channel
// factor by the brightness, and stage five scales by 255 into the output register. Every
// stage holds its own valid bit, so a stall on the rgb side fills bubbles first and only
// then drops pixel_ready.
module hsb_to_rgb_converter
    import hsbrgb_pkg::*;
#(
    parameter int HUE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  logic [HUE_BITS-1:0] hue,
    input  sat_bri_t            sat_bri,
    output logic                rgb_valid,
    input  logic                rgb_ready,
    output rgb_t                rgb
);

    localparam int H6_W   = HUE_BITS + 3;
    localparam int FAC_W  = HUE_BITS + 16;
    localparam int NUM_W  = HUE_BITS + 32;
    localparam int PRD_W  = NUM_W + 8;
    localparam int OUT_LO = HUE_BITS + 30;
    localparam int STAGES = 5;

    localparam logic [FAC_W-1:0] FAC_ONE = FAC_W'(1) << (HUE_BITS + 15);
    localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1) << (HUE_BITS + 30);
    localparam logic [HUE_BITS:0] HUE_ONE = (HUE_BITS + 1)'(1) << HUE_BITS;

    // Per-stage valid and ready chain
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES:0]   rdy;

    always_comb
    begin
        rdy[STAGES] = rgb_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_comb
    begin
        if (rdy[0])
        begin
            vld_next[0] = pixel_valid;
        end
        else
        begin
            vld_next[0] = vld_reg[0];
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pixel_ready = rdy[0];
    assign rgb_valid   = vld_reg[STAGES-1];

    // Stage 1: clamp, hue * 6 into sector and fraction
    logic [H6_W-1:0]     h6;
    logic [2:0]          s1_sector_reg;
    logic [HUE_BITS-1:0] s1_f_reg;
    logic [15:0]         s1_s_reg;
    logic [15:0]         s1_v_reg;

    assign h6 = H6_W'({hue, 2'b00}) + H6_W'({hue, 1'b0});

    always_ff @(posedge clk)
    begin
        if (rdy[0] && pixel_valid)
        begin
            s1_sector_reg <= h6[H6_W-1:HUE_BITS];
            s1_f_reg      <= h6[HUE_BITS-1:0];
            s1_s_reg      <= clamp_q15(sat_bri.saturation);
            s1_v_reg      <= clamp_q15(sat_bri.brightness);
        end
    end

    // Stage 2: s * f, s * (1 - f), 1 - s
    logic [HUE_BITS:0] fc;
    logic [2:0]        s2_sector_reg;
    logic [FAC_W-1:0]  s2_sf_reg;
    logic [FAC_W-1:0]  s2_sfc_reg;
    logic [15:0]       s2_pf_reg;
    logic [15:0]       s2_v_reg;

    assign fc = HUE_ONE - {1'b0, s1_f_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[1] && vld_reg[0])
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_sf_reg     <= FAC_W'(s1_s_reg) * FAC_W'(s1_f_reg);
            s2_sfc_reg    <= FAC_W'(s1_s_reg) * FAC_W'(fc);
            s2_pf_reg     <= Q15_ONE - s1_s_reg;
            s2_v_reg      <= s1_v_reg;
        end
    end

    // Stage 3: p, q, t factors routed per sector
    logic [FAC_W-1:0] p_fac;
    logic [FAC_W-1:0] q_fac;
    logic [FAC_W-1:0] t_fac;
    logic [FAC_W-1:0] r_fac_next;
    logic [FAC_W-1:0] g_fac_next;
    logic [FAC_W-1:0] b_fac_next;
    logic [FAC_W-1:0] s3_r_fac_reg;
    logic [FAC_W-1:0] s3_g_fac_reg;
    logic [FAC_W-1:0] s3_b_fac_reg;
    logic [15:0]      s3_v_reg;

    assign p_fac = {s2_pf_reg, HUE_BITS'(0)};
    assign q_fac = FAC_ONE - s2_sf_reg;
    assign t_fac = FAC_ONE - s2_sfc_reg;

    always_comb
    begin
        unique case (s2_sector_reg)
            SECTOR_RED_YEL:
            begin
                r_fac_next = FAC_ONE;
                g_fac_next = t_fac;
                b_fac_next = p_fac;
            end
            SECTOR_YEL_GRN:
            begin
                r_fac_next = q_fac;
                g_fac_next = FAC_ONE;
                b_fac_next = p_fac;
            end
            SECTOR_GRN_CYN:
            begin
                r_fac_next = p_fac;
                g_fac_next = FAC_ONE;
                b_fac_next = t_fac;
            end
            SECTOR_CYN_BLU:
            begin
                r_fac_next = p_fac;
                g_fac_next = q_fac;
                b_fac_next = FAC_ONE;
            end
            SECTOR_BLU_MAG:
            begin
                r_fac_next = t_fac;
                g_fac_next = p_fac;
                b_fac_next = FAC_ONE;
            end
            default:
            begin
                r_fac_next = FAC_ONE;
                g_fac_next = p_fac;
                b_fac_next = q_fac;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2] && vld_reg[1])
        begin
            s3_r_fac_reg <= r_fac_next;
            s3_g_fac_reg <= g_fac_next;
            s3_b_fac_reg <= b_fac_next;
            s3_v_reg     <= s2_v_reg;
        end
    end

    // Stage 4: channel value = brightness * factor
    logic [NUM_W-1:0] s4_r_reg;
    logic [NUM_W-1:0] s4_g_reg;
    logic [NUM_W-1:0] s4_b_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3] && vld_reg[2])
        begin
            s4_r_reg <= NUM_W'(s3_v_reg) * NUM_W'(s3_r_fac_reg);
            s4_g_reg <= NUM_W'(s3_v_reg) * NUM_W'(s3_g_fac_reg);
            s4_b_reg <= NUM_W'(s3_v_reg) * NUM_W'(s3_b_fac_reg);
        end
    end

    // Stage 5: times 255 by shift and subtract, keep the integer byte
    logic [PRD_W-1:0] r_prd;
    logic [PRD_W-1:0] g_prd;
    logic [PRD_W-1:0] b_prd;
    rgb_t             rgb_reg;

    assign r_prd = {s4_r_reg, 8'd0} - {8'd0, s4_r_reg};
    assign g_prd = {s4_g_reg, 8'd0} - {8'd0, s4_g_reg};
    assign b_prd = {s4_b_reg, 8'd0} - {8'd0, s4_b_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[4] && vld_reg[3])
        begin
            rgb_reg.red   <= r_prd[OUT_LO+7:OUT_LO];
            rgb_reg.green <= g_prd[OUT_LO+7:OUT_LO];
            rgb_reg.blue  <= b_prd[OUT_LO+7:OUT_LO];
        end
    end

    assign rgb = rgb_reg;

`ifndef SYNTHESIS
    // Sector stays within the six hue sectors
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> s1_sector_reg <= SECTOR_MAG_RED)
        else $error("hue sector out of range");

    // Channel factors never exceed 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (s3_r_fac_reg <= FAC_ONE && s3_g_fac_reg <= FAC_ONE
                        && s3_b_fac_reg <= FAC_ONE))
        else $error("channel factor above one");

    // Channel values never exceed 1.0, so the byte cannot wrap
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (s4_r_reg <= NUM_ONE && s4_g_reg <= NUM_ONE
                        && s4_b_reg <= NUM_ONE))
        else $error("channel value above one");

    // A stalled stage three keeps its pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && !rdy[3] |=> vld_reg[2] && $stable(s3_r_fac_reg))
        else $error("stalled pixel lost in stage three");
`endif

endmodule
